@@ hdl/ffba_pkg.sv @@
// Package for the first-fit block allocator: widths, status codes, request type codes.
// No dependencies.
`default_nettype none
package ffba_pkg;
	localparam int MAX_BLOCKS_DEF = 32;
	localparam int ADDR_BITS_DEF  = 16;
	localparam int SIZE_W         = 17;
	localparam int STAT_W         = 3;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd2;
	localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

	localparam logic REQ_CLAIM = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_SIZE  = 1'b1;
endpackage
`default_nettype wire

@@ hdl/ffba_if.sv @@
// Channel interfaces: request, result and configuration write channels.
// Depends on ffba_pkg.
`default_nettype none
interface ffba_req_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SIZE_W-1:0] req_size;
	logic [15:0]       req_addr;
	modport source (output valid, req_type, req_size, req_addr, input ready);
	modport sink (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [15:0]       block_addr;
	logic [SIZE_W-1:0] freed_size;
	modport source (output valid, status, block_addr, freed_size, input ready);
	modport sink (input valid, status, block_addr, freed_size, output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/ffba_table.sv @@
// One address-ordered table: a memory of start/length entries, one write and one
// registered read port per cycle. Depends on ffba_pkg.
`default_nettype none
module ffba_table import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	localparam int IDX_W     = $clog2(MAX_BLOCKS)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IDX_W-1:0]     waddr,
	input  wire logic [ADDR_BITS-1:0] wstart,
	input  wire logic [ADDR_BITS:0]   wlen,
	input  wire logic [IDX_W-1:0]     raddr,
	output logic      [ADDR_BITS-1:0] rstart,
	output logic      [ADDR_BITS:0]   rlen
);
	logic [ADDR_BITS-1:0] start_mem [MAX_BLOCKS];
	logic [ADDR_BITS:0]   len_mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			len_mem[waddr]   <= wlen;
		end
		rstart <= start_mem[raddr];
		rlen   <= len_mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
// Top level of the first-fit allocator: sequencer, shared compare/add unit, two tables.
// Depends on ffba_pkg, ffba_if, ffba_table.
//
//  channel | dir | payload
//  req     | in  | req_type, req_size, req_addr
//  rsp     | out | status, block_addr, freed_size
//  cfg     | in  | index, data (0 region_start, 1 region_size)
//
// A request runs over up to two table scans and two table shifts; each shift step is one
// registered read then one write on the one-read, one-write table memories. A config
// write resets the counts and rewrites free entry 0. After reset release the block
// writes free entry 0 with the whole region before it takes a request.
// The result waits in an output register; the next request is taken once it is taken.
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp,
	ffba_cfg_if.sink   cfg
);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int L_W   = ADDR_BITS + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_FSCAN_RD, S_FSCAN_CHK, S_USCAN_RD, S_USCAN_CHK,
		S_SH_RD, S_SH_WR, S_FIN_WR, S_FIN2_WR, S_RESP
	} state_t;

	// shift job descriptor: direction and bounds
	typedef struct packed {
		logic             up;    // 1: move entries toward higher index (insert)
		logic             tbl;   // 0 free table, 1 used table
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] stop;
	} shift_t;

	state_t state_q;
	shift_t sh_q;
	logic [ADDR_BITS-1:0] rstart_q;
	logic [L_W-1:0] rsize_q;
	logic region_ok_q;
	logic [CNT_W-1:0] fcnt_q, ucnt_q, i_q, pos_q;
	logic type_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [L_W-1:0] size_q, len_q;
	logic [ADDR_BITS-1:0] prev_start_q;
	logic [L_W-1:0] prev_len_q;
	logic prev_q, jn_q, jp_q;
	logic [1:0] phase_q;   // claim: 0 free scan, 1 used scan; free: 0 used scan, 1 free scan
	logic [ADDR_BITS-1:0] cur_start_q, fit_start_q;
	logic [L_W-1:0] cur_len_q, fit_len_q;
	logic [STAT_W-1:0] st_q;
	logic [ADDR_BITS-1:0] baddr_q;
	logic [L_W-1:0] fsize_q;

	// table ports
	logic f_we, u_we;
	logic [IDX_W-1:0] f_wa, u_wa, f_ra, u_ra;
	logic [ADDR_BITS-1:0] f_ws, u_ws, f_rs, u_rs;
	logic [L_W-1:0] f_wl, u_wl, f_rl, u_rl;

	ffba_table #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_free (
		.clk, .we(f_we), .waddr(f_wa), .wstart(f_ws), .wlen(f_wl),
		.raddr(f_ra), .rstart(f_rs), .rlen(f_rl));
	ffba_table #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_used (
		.clk, .we(u_we), .waddr(u_wa), .wstart(u_ws), .wlen(u_wl),
		.raddr(u_ra), .rstart(u_rs), .rlen(u_rl));

	// shared adder/comparator
	logic [L_W:0] add_a, add_b, add_sum;
	assign add_sum = add_a + add_b;

	logic [L_W:0] region_end;
	assign region_end = {1'b0, {1'b0, rstart_q} + rsize_q};

	// a pending config write goes first
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_RESP);
	assign rsp.status = st_q;
	assign rsp.block_addr = 16'(baddr_q);
	assign rsp.freed_size = SIZE_W'(fsize_q);

	// read index: scans read at i_q, shift reads the neighbor
	always_comb begin
		f_ra = IDX_W'(i_q);
		u_ra = IDX_W'(i_q);
		if (state_q == S_SH_RD || state_q == S_SH_WR) begin
			f_ra = IDX_W'(sh_q.up ? sh_q.j - CNT_ONE : sh_q.j + CNT_ONE);
			u_ra = f_ra;
		end
	end

	// adder operand select and table writes
	always_comb begin
		add_a = '0;
		add_b = '0;
		f_we = 1'b0; u_we = 1'b0;
		f_wa = '0; u_wa = '0;
		f_ws = '0; u_ws = '0;
		f_wl = '0; u_wl = '0;
		case (state_q)
			S_FSCAN_CHK: begin
				if (type_q == REQ_FREE) begin
					add_a = {1'b0, 1'b0, prev_start_q};
					add_b = {1'b0, prev_len_q};
				end
			end
			S_SH_WR: begin
				if (sh_q.tbl) begin
					u_we = 1'b1; u_wa = IDX_W'(sh_q.j); u_ws = u_rs; u_wl = u_rl;
				end else begin
					f_we = 1'b1; f_wa = IDX_W'(sh_q.j); f_ws = f_rs; f_wl = f_rl;
				end
			end
			S_FIN_WR: begin
				if (phase_q == 2'd2) begin
					// removal shift done; nothing left to write
				end else if (type_q == REQ_CLAIM) begin
					u_we = 1'b1; u_wa = IDX_W'(pos_q); u_ws = fit_start_q; u_wl = size_q;
				end else if (!sh_q.tbl) begin
					add_a = {1'b0, len_q};
					f_we = 1'b1;
					if (jp_q && jn_q) begin
						add_b = {1'b0, prev_len_q} + {1'b0, cur_len_q};
						f_wa = IDX_W'(pos_q - CNT_ONE); f_ws = prev_start_q;
					end else if (jp_q) begin
						add_b = {1'b0, prev_len_q};
						f_wa = IDX_W'(pos_q - CNT_ONE); f_ws = prev_start_q;
					end else if (jn_q) begin
						add_b = {1'b0, cur_len_q};
						f_wa = IDX_W'(pos_q); f_ws = addr_q;
					end else begin
						f_wa = IDX_W'(pos_q); f_ws = addr_q;
					end
					f_wl = L_W'(add_sum);
				end
			end
			S_FIN2_WR: begin
				// claim with remainder: shrink the fit entry in place; on a rebuild, write free entry 0
				add_a = {1'b0, 1'b0, fit_start_q};
				add_b = {1'b0, size_q};
				f_we = 1'b1; f_wa = IDX_W'(i_q);
				f_ws = ADDR_BITS'(add_sum);
				f_wl = fit_len_q - size_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// first cycles after reset write free entry 0 with the whole region
			state_q <= S_SH_RD;
			rstart_q <= '0;
			rsize_q <= L_W'(1) << ADDR_BITS;
			region_ok_q <= 1'b1;
			fcnt_q <= CNT_ONE;
			ucnt_q <= '0;
			i_q <= '0; pos_q <= '0; phase_q <= 2'd3;
			sh_q <= '0;
			st_q <= ST_OK;
			fit_start_q <= '0;
			fit_len_q <= L_W'(1) << ADDR_BITS;
			size_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg.valid && cfg.index <= 8'(CFG_REGION_SIZE)) begin
						logic [ADDR_BITS-1:0] ns;
						logic [L_W-1:0] nz;
						logic [L_W:0] e;
						ns = (cfg.index == 8'(CFG_REGION_START))
							? ADDR_BITS'(cfg.data[15:0]) : rstart_q;
						nz = (cfg.index == 8'(CFG_REGION_SIZE))
							? L_W'(cfg.data[16:0]) : rsize_q;
						e = {2'b0, ns} + {1'b0, nz};
						rstart_q <= ns;
						rsize_q <= nz;
						region_ok_q <= (nz != '0) && (e <= ((L_W+1)'(1) << ADDR_BITS));
						fcnt_q <= ((nz != '0) && (e <= ((L_W+1)'(1) << ADDR_BITS)))
							? CNT_ONE : '0;
						ucnt_q <= '0;
						state_q <= S_SH_RD;  // write entry 0 of free table next
						sh_q <= '0;
						i_q <= '0;
						fit_start_q <= ns; fit_len_q <= nz; size_q <= '0;
						type_q <= REQ_CLAIM;
						phase_q <= 2'd3;     // marks the rebuild write
					end else if (req.valid && !cfg.valid) begin
						type_q <= req.req_type;
						size_q <= L_W'(req.req_size);
						addr_q <= ADDR_BITS'(req.req_addr);
						baddr_q <= '0; fsize_q <= '0;
						i_q <= '0; phase_q <= '0; prev_q <= 1'b0;
						if (!region_ok_q) begin
							st_q <= ST_OUTSIDE; state_q <= S_RESP;
						end else if (req.req_type == REQ_CLAIM) begin
							if (req.req_size == '0 || L_W'(req.req_size) > rsize_q) begin
								st_q <= ST_BAD_SIZE; state_q <= S_RESP;
							end else begin
								state_q <= S_FSCAN_RD;
							end
						end else begin
							if ({1'b0, L_W'(req.req_addr)} < {1'b0, L_W'(rstart_q)} ||
								{2'b0, L_W'(req.req_addr)} >= {1'b0, region_end}) begin
								st_q <= ST_OUTSIDE; state_q <= S_RESP;
							end else begin
								state_q <= S_USCAN_RD;
							end
						end
					end
				end
				S_FSCAN_RD: begin
					// free table scan; for claim find fit, for free find pos
					if (i_q >= fcnt_q) begin
						if (type_q == REQ_CLAIM) begin
							st_q <= ST_NO_FIT; state_q <= S_RESP;
						end else begin
							pos_q <= i_q; jn_q <= 1'b0;
							jp_q <= 1'b0;
							state_q <= S_FSCAN_CHK;
						end
					end else begin
						state_q <= S_FSCAN_CHK;
					end
				end
				S_FSCAN_CHK: begin
					if (type_q == REQ_CLAIM) begin
						if (f_rl >= size_q) begin
							if (ucnt_q >= CNT_MAX) begin
								st_q <= ST_FULL; state_q <= S_RESP;
							end else begin
								fit_start_q <= f_rs; fit_len_q <= f_rl;
								pos_q <= i_q;  // fit index kept in pos until used scan
								phase_q <= 2'd1;
								i_q <= '0;
								state_q <= S_USCAN_RD;
							end
						end else begin
							i_q <= i_q + CNT_ONE; state_q <= S_FSCAN_RD;
						end
					end else begin
						if (i_q < fcnt_q && f_rs < addr_q) begin
							prev_q <= 1'b1; prev_start_q <= f_rs; prev_len_q <= f_rl;
							i_q <= i_q + CNT_ONE; state_q <= S_FSCAN_RD;
						end else begin
							logic p, n;
							p = prev_q && (add_sum == {2'b0, L_W'(addr_q)});
							n = (i_q < fcnt_q) &&
								({2'b0, L_W'(addr_q)} + {1'b0, len_q} == {2'b0, L_W'(f_rs)});
							pos_q <= i_q; jp_q <= p; jn_q <= n;
							cur_len_q <= f_rl;
							if (!p && !n && fcnt_q >= CNT_MAX) begin
								st_q <= ST_FULL; state_q <= S_RESP;
							end else begin
								// remove used entry i (kept in fit_start_q idx slot)
								sh_q <= '{up: 1'b0, tbl: 1'b1,
									j: CNT_W'(fit_start_q), stop: ucnt_q - CNT_ONE};
								state_q <= S_SH_RD;
							end
						end
					end
				end
				S_USCAN_RD: begin
					if (i_q >= ucnt_q) begin
						if (type_q == REQ_FREE) begin
							st_q <= ST_NOT_ALLOC; state_q <= S_RESP;
						end else begin
							state_q <= S_USCAN_CHK;
						end
					end else begin
						state_q <= S_USCAN_CHK;
					end
				end
				S_USCAN_CHK: begin
					if (type_q == REQ_FREE) begin
						if (u_rs == addr_q) begin
							len_q <= u_rl;
							fit_start_q <= ADDR_BITS'(i_q);  // used index to remove
							i_q <= '0; phase_q <= 2'd1;
							state_q <= S_FSCAN_RD;
						end else begin
							i_q <= i_q + CNT_ONE; state_q <= S_USCAN_RD;
						end
					end else if (i_q < ucnt_q && u_rs < fit_start_q) begin
						i_q <= i_q + CNT_ONE; state_q <= S_USCAN_RD;
					end else begin
						// insert slot found at i_q; fit index in pos_q
						sh_q <= '{up: 1'b1, tbl: 1'b1, j: ucnt_q, stop: i_q};
						cur_len_q <= L_W'(pos_q);
						pos_q <= i_q;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (phase_q == 2'd3) begin
						state_q <= S_FIN2_WR;
					end else if (sh_q.up ? (sh_q.j <= sh_q.stop) : (sh_q.j >= sh_q.stop)) begin
						state_q <= S_FIN_WR;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					sh_q.j <= sh_q.up ? sh_q.j - CNT_ONE : sh_q.j + CNT_ONE;
					state_q <= S_SH_RD;
				end
				S_FIN_WR: begin
					if (type_q == REQ_CLAIM) begin
						if (sh_q.tbl) begin
							// used entry written; now fix free table
							ucnt_q <= ucnt_q + CNT_ONE;
							i_q <= CNT_W'(cur_len_q);
							baddr_q <= fit_start_q;
							st_q <= ST_OK;
							if (fit_len_q > size_q) begin
								state_q <= S_FIN2_WR;
							end else begin
								sh_q <= '{up: 1'b0, tbl: 1'b0, j: CNT_W'(cur_len_q),
									stop: fcnt_q - CNT_ONE};
								fcnt_q <= fcnt_q - CNT_ONE;
								type_q <= REQ_FREE;   // reuse: shift-only pass
								phase_q <= 2'd2;
								state_q <= S_SH_RD;
							end
						end
					end else if (phase_q == 2'd2) begin
						// plain removal shift finished
						state_q <= S_RESP;
					end else if (sh_q.tbl) begin
						ucnt_q <= ucnt_q - CNT_ONE;
						if (!jp_q && !jn_q) begin
							sh_q <= '{up: 1'b1, tbl: 1'b0, j: fcnt_q, stop: pos_q};
							fcnt_q <= fcnt_q + CNT_ONE;
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_FIN_WR;
							sh_q.tbl <= 1'b0;
							sh_q.j <= pos_q; sh_q.stop <= pos_q;
						end
					end else begin
						st_q <= ST_OK;
						fsize_q <= len_q;
						if (jp_q && jn_q) begin
							sh_q <= '{up: 1'b0, tbl: 1'b0, j: pos_q, stop: fcnt_q - CNT_ONE};
							fcnt_q <= fcnt_q - CNT_ONE;
							phase_q <= 2'd2;
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_FIN2_WR: begin
					state_q <= (phase_q == 2'd3) ? S_IDLE : S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ucnt_q <= CNT_MAX)
		else $error("used count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) fcnt_q <= CNT_MAX)
		else $error("free count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && st_q != ST_OK) |-> (baddr_q == '0 && fsize_q == '0))
		else $error("payload on error response");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("response dropped");
endmodule
`default_nettype wire

@@ verif/ffba_tb_scoreboard.sv @@
// Allocation predictor and result scoreboard for the first-fit block allocator bench.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
import ffba_pkg::*;

class ffba_tb_scoreboard;
	localparam int DEPTH = MAX_BLOCKS_DEF;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [15:0]       block_addr;
		logic [SIZE_W-1:0] freed_size;
	} alloc_result_t;

	int unsigned base;
	int unsigned span;
	bit          region_valid;
	int unsigned hole_start[DEPTH];
	int unsigned hole_len[DEPTH];
	int unsigned hole_cnt;
	int unsigned grant_start[DEPTH];
	int unsigned grant_len[DEPTH];
	int unsigned grant_cnt;
	alloc_result_t pending[$];
	int unsigned errors;
	int unsigned matched;
	int unsigned n_stat[8];

	function new();
		base = 0;
		span = 65536;
		errors = 0;
		matched = 0;
		foreach (n_stat[i]) n_stat[i] = 0;
		rebuild_tables();
	endfunction

	function void rebuild_tables();
		grant_cnt = 0;
		region_valid = span != 0 && base + span <= 65536;
		if (region_valid) begin
			hole_start[0] = base;
			hole_len[0] = span;
			hole_cnt = 1;
		end else begin
			hole_cnt = 0;
		end
	endfunction

	function void set_reg(logic idx, int unsigned value);
		if (idx == CFG_REGION_START)
			base = value & 16'hFFFF;
		else
			span = value & 17'h1FFFF;
		rebuild_tables();
	endfunction

	function alloc_result_t claim_block(int unsigned len);
		alloc_result_t r;
		int unsigned i, j, pos, a;
		r = '0;
		if (len == 0 || len > span) begin
			r.status = ST_BAD_SIZE;
			return r;
		end
		for (i = 0; i < hole_cnt; i++)
			if (hole_len[i] >= len) break;
		if (i >= hole_cnt) begin
			r.status = ST_NO_FIT;
			return r;
		end
		if (grant_cnt >= DEPTH) begin
			r.status = ST_FULL;
			return r;
		end
		a = hole_start[i];
		if (hole_len[i] > len) begin
			hole_start[i] = a + len;
			hole_len[i] -= len;
		end else begin
			for (j = i; j + 1 < hole_cnt; j++) begin
				hole_start[j] = hole_start[j+1];
				hole_len[j] = hole_len[j+1];
			end
			hole_cnt--;
		end
		pos = 0;
		while (pos < grant_cnt && grant_start[pos] < a) pos++;
		for (j = grant_cnt; j > pos; j--) begin
			grant_start[j] = grant_start[j-1];
			grant_len[j] = grant_len[j-1];
		end
		grant_start[pos] = a;
		grant_len[pos] = len;
		grant_cnt++;
		r.status = ST_OK;
		r.block_addr = a[15:0];
		return r;
	endfunction

	function alloc_result_t release_block(int unsigned a);
		alloc_result_t r;
		int unsigned i, j, pos, len;
		bit prev_touch, next_touch;
		r = '0;
		if (a < base || a >= base + span) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		for (i = 0; i < grant_cnt; i++)
			if (grant_start[i] == a) break;
		if (i >= grant_cnt) begin
			r.status = ST_NOT_ALLOC;
			return r;
		end
		len = grant_len[i];
		pos = 0;
		while (pos < hole_cnt && hole_start[pos] < a) pos++;
		prev_touch = pos > 0 && hole_start[pos-1] + hole_len[pos-1] == a;
		next_touch = pos < hole_cnt && a + len == hole_start[pos];
		if (!prev_touch && !next_touch && hole_cnt >= DEPTH) begin
			r.status = ST_FULL;
			return r;
		end
		for (j = i; j + 1 < grant_cnt; j++) begin
			grant_start[j] = grant_start[j+1];
			grant_len[j] = grant_len[j+1];
		end
		grant_cnt--;
		if (prev_touch && next_touch) begin
			hole_len[pos-1] += len + hole_len[pos];
			for (j = pos; j + 1 < hole_cnt; j++) begin
				hole_start[j] = hole_start[j+1];
				hole_len[j] = hole_len[j+1];
			end
			hole_cnt--;
		end else if (prev_touch) begin
			hole_len[pos-1] += len;
		end else if (next_touch) begin
			hole_start[pos] = a;
			hole_len[pos] += len;
		end else begin
			for (j = hole_cnt; j > pos; j--) begin
				hole_start[j] = hole_start[j-1];
				hole_len[j] = hole_len[j-1];
			end
			hole_start[pos] = a;
			hole_len[pos] = len;
			hole_cnt++;
		end
		r.status = ST_OK;
		r.freed_size = len[SIZE_W-1:0];
		return r;
	endfunction

	function void note_request(logic kind, logic [SIZE_W-1:0] len, logic [15:0] a);
		alloc_result_t r;
		if (!region_valid) begin
			r = '0;
			r.status = ST_OUTSIDE;
		end else if (kind == REQ_CLAIM) begin
			r = claim_block(len);
		end else begin
			r = release_block(a);
		end
		pending.push_back(r);
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(logic [STAT_W-1:0] st, logic [15:0] a, logic [SIZE_W-1:0] len);
		alloc_result_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result status %0d", st));
			return;
		end
		e = pending.pop_front();
		n_stat[e.status]++;
		if (st !== e.status)
			report($sformatf("status got %0d want %0d", st, e.status));
		else if (a !== e.block_addr)
			report($sformatf("block_addr got %h want %h", a, e.block_addr));
		else if (len !== e.freed_size)
			report($sformatf("freed_size got %h want %h", len, e.freed_size));
		else
			matched++;
	endtask
endclass

@@ verif/tb_first_fit_block_allocator.sv @@
// Top-level bench for first_fit_block_allocator: drives claims and frees with random
// gaps, checks every result against the allocation predictor.
// Depends on ffba_pkg, ffba_if, ffba_tb_scoreboard.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   rsp_done = 1'b0;

	ffba_req_if req ();
	ffba_rsp_if rsp ();
	ffba_cfg_if cfg ();

	first_fit_block_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	ffba_tb_scoreboard alloc_sb = new();
	int unsigned live_addrs[$];
	int unsigned n_requests = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_CLAIM;
		req.req_size = '0;
		req.req_addr = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic wait_cycles(int unsigned n);
		repeat (n) @(posedge clk);
	endtask

	// request sender; random gaps before each request when gaps is set
	task automatic send_request(logic kind, logic [SIZE_W-1:0] len, logic [15:0] a,
		bit gaps);
		if (gaps) wait_cycles(pick_gap());
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.req_size <= len;
		req.req_addr <= a;
		do @(posedge clk); while (!req.ready);
		alloc_sb.note_request(kind, len, a);
		n_requests++;
		req.valid <= 1'b0;
		// block leaves idle once it takes a request anyway
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		cfg.valid <= 1'b1;
		cfg.index <= {7'd0, idx};
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		alloc_sb.set_reg(idx, value);
		cfg.valid <= 1'b0;
		live_addrs.delete();
		@(posedge clk);
	endtask

	task automatic drain();
		while (alloc_sb.pending.size() != 0) @(posedge clk);
		wait_cycles(4 * MAX_BLOCKS_DEF + 20);
	endtask

	task automatic claim_and_track(logic [SIZE_W-1:0] len);
		send_request(REQ_CLAIM, len, '0, 1'b1);
		// predictor already ran; record grant if it succeeded
		if (alloc_sb.pending[$].status == ST_OK)
			live_addrs.push_back(alloc_sb.pending[$].block_addr);
	endtask

	task automatic free_tracked();
		int unsigned k;
		k = $urandom_range(0, live_addrs.size() - 1);
		send_request(REQ_FREE, '0, live_addrs[k][15:0], 1'b1);
		if (alloc_sb.pending[$].status == ST_OK) live_addrs.delete(k);
	endtask

	task automatic random_phase(int unsigned n, int unsigned max_len);
		int unsigned r;
		logic [15:0] a;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				claim_and_track(SIZE_W'($urandom_range(1, max_len)));
			end else if (r < 80 && live_addrs.size() != 0) begin
				free_tracked();
			end else if (r < 90) begin
				a = 16'($urandom);
				send_request(REQ_FREE, SIZE_W'($urandom), a, 1'b1);
			end else begin
				send_request(REQ_CLAIM, SIZE_W'($urandom_range(0, 131071)), 16'($urandom),
					1'b1);
			end
		end
	endtask

	// result sink with random stalls, sometimes none
	initial begin
		int unsigned mode;
		@(posedge arst_n);
		while (!rsp_done) begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				if (mode == 0) rsp.ready <= 1'b1;
				else rsp.ready <= (pick_gap() == 0);
				@(posedge clk);
				if (rsp.valid && rsp.ready)
					alloc_sb.check_result(rsp.status, rsp.block_addr, rsp.freed_size);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		wait_cycles(2);
		arst_n <= 1'b1;
		wait_cycles(2);

		// directed: default region extremes
		send_request(REQ_CLAIM, '0, '0, 1'b0);
		send_request(REQ_CLAIM, 17'd65537 & 17'h1FFFF, 16'hFFFF, 1'b0);
		send_request(REQ_CLAIM, 17'd65536, '0, 1'b0);
		send_request(REQ_FREE, 17'h1FFFF, 16'h0000, 1'b0);
		send_request(REQ_CLAIM, 17'd1, '0, 1'b0);
		send_request(REQ_FREE, '0, 16'hFFFF, 1'b0);
		send_request(REQ_FREE, '0, 16'h1234, 1'b0);
		drain();

		// small region near the top; fill the used table
		write_reg(CFG_REGION_START, 32'd65472);
		write_reg(CFG_REGION_SIZE, 32'd64);
		send_request(REQ_FREE, '0, 16'd100, 1'b0);
		send_request(REQ_CLAIM, 17'd65, '0, 1'b0);
		repeat (33) claim_and_track(17'd2);
		send_request(REQ_CLAIM, 17'd1, '0, 1'b0);
		// free every other block to split the free list
		for (int i = 0; i < 32; i += 2) send_request(REQ_FREE, '0, 16'(65472 + 2*i), 1'b0);
		send_request(REQ_FREE, '0, 16'd65474, 1'b0);
		send_request(REQ_FREE, '0, 16'd65473, 1'b0);
		drain();

		// invalid regions, then a one-entry region at the top
		write_reg(CFG_REGION_SIZE, 32'd0);
		send_request(REQ_CLAIM, 17'd1, '0, 1'b0);
		drain();
		write_reg(CFG_REGION_START, 32'd65535);
		write_reg(CFG_REGION_SIZE, 32'd2);
		send_request(REQ_FREE, '0, 16'hFFFF, 1'b0);
		drain();
		write_reg(CFG_REGION_SIZE, 32'd1);
		send_request(REQ_CLAIM, 17'd1, '0, 1'b0);
		send_request(REQ_FREE, '0, 16'hFFFF, 1'b0);
		drain();

		// random phases over several regions
		write_reg(CFG_REGION_START, 32'd0);
		write_reg(CFG_REGION_SIZE, 32'd65536);
		random_phase(200, 4096);
		drain();
		write_reg(CFG_REGION_START, 32'd4096);
		write_reg(CFG_REGION_SIZE, 32'd200);
		random_phase(250, 12);
		drain();
		write_reg(CFG_REGION_START, $urandom_range(0, 32767));
		write_reg(CFG_REGION_SIZE, $urandom_range(100, 1000));
		random_phase(200, 40);
		drain();
		write_reg(CFG_REGION_START, 32'd0);
		write_reg(CFG_REGION_SIZE, 32'd65536);
		random_phase(150, 65536);
		drain();
		rsp_done = 1'b1;

		$display("requests sent %0d, results matched %0d", n_requests, alloc_sb.matched);
		$display("ok %0d bad size %0d no fit %0d outside %0d not alloc %0d full %0d",
			alloc_sb.n_stat[ST_OK], alloc_sb.n_stat[ST_BAD_SIZE], alloc_sb.n_stat[ST_NO_FIT],
			alloc_sb.n_stat[ST_OUTSIDE], alloc_sb.n_stat[ST_NOT_ALLOC], alloc_sb.n_stat[ST_FULL]);
		if (alloc_sb.errors == 0 && alloc_sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ first_fit_block_allocator.f @@
hdl/ffba_pkg.sv
hdl/ffba_if.sv
hdl/ffba_table.sv
hdl/first_fit_block_allocator.sv
verif/ffba_tb_scoreboard.sv
verif/tb_first_fit_block_allocator.sv
